// File: rtl/elastic_contact_pair_force_unit_macros.svh
// Assertion helpers used by the checker file.
`ifndef ELASTIC_CONTACT_PAIR_FORCE_UNIT_MACROS_SVH
`define ELASTIC_CONTACT_PAIR_FORCE_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, muted while arst_n is low.
`define ECPF_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ecpf check failed");

// Next-cycle implication, sampled on clk, muted while arst_n is low.
`define ECPF_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ecpf check failed");

`endif

// File: rtl/ecpf_pkg.sv
`default_nettype none

package ecpf_pkg;

	localparam int DIMENSIONS = 3;

	// queue between front and back
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	// pipeline step counts
	localparam int D_BITS  = 34;
	localparam int RD_BITS = 31;
	localparam int SO_BITS = 25;
	localparam int Q_BITS  = 32;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_ENERGY  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_USE_CUT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CUT_LEN = 2'd2;

	localparam logic [30:0] ENERGY_RST  = 31'd17476;
	localparam logic [30:0] CUT_LEN_RST = 31'd98304;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_CUTOFF   = 2'd1;
	localparam logic [1:0] ST_COINCIDE = 2'd2;
	localparam logic [1:0] ST_SAT      = 2'd3;

	typedef struct packed {
		logic signed [31:0] a_x;
		logic signed [31:0] a_y;
		logic signed [31:0] a_z;
		logic signed [31:0] b_x;
		logic signed [31:0] b_y;
		logic signed [31:0] b_z;
		logic [30:0]        radius_a;
		logic [30:0]        radius_b;
	} item_t;

	typedef struct packed {
		logic signed [31:0] force_x;
		logic signed [31:0] force_y;
		logic signed [31:0] force_z;
		logic [1:0]         status;
	} result_t;

	typedef struct packed {
		logic [30:0] energy;
		logic        use_cut;
		logic [30:0] cut_len;
	} cfg_t;

	// classified word handed from front to back
	typedef struct packed {
		logic [2:0][32:0] ad;
		logic [2:0]       neg;
		logic [30:0]      r1;
		logic [30:0]      r2;
		logic [32:0]      s;
	} fe_word_t;

	typedef struct packed {
		logic [33:0] r;
		logic [67:0] sq;
	} root_t;

	typedef struct packed {
		logic [65:0] rem;
		logic        q;
	} dstep_t;

	// one restoring square root step: try result bit b
	function automatic root_t sqrt_step(input logic [67:0] n, input root_t cur, input int b);
		root_t res;
		logic [67:0] t;
		t = cur.sq + ({34'd0, cur.r} << (b + 1)) + (68'd1 << (2 * b));
		if (t <= n) begin
			res.r = cur.r | (34'd1 << b);
			res.sq = t;
		end else begin
			res = cur;
		end
		return res;
	endfunction

	// one restoring division step: shift in one numerator bit
	function automatic dstep_t div_step(input logic [65:0] rem, input logic [65:0] den,
			input logic bin);
		dstep_t res;
		logic [65:0] t;
		t = {rem[64:0], bin};
		if (t >= den) begin
			res.rem = t - den;
			res.q = 1'b1;
		end else begin
			res.rem = t;
			res.q = 1'b0;
		end
		return res;
	endfunction

endpackage

`default_nettype wire

// File: rtl/elastic_contact_pair_force_unit.sv
`default_nettype none

// Contact force between two spherical cells, Q16.16 throughout. Pulse start
// with a pair on item while busy is low; the pair is taken at that edge. One
// pair may be taken every cycle while busy is low. Each pair yields exactly
// one word on result, marked by a one-cycle done pulse. The back end is built
// of bit-per-stage pipelines: the 34-step distance root, the 25-step overlap
// roots and the 32-step quotient. There is no way to hold results off, so
// capture result whenever done is high. busy only rises if the front-to-back
// queue nearly fills, which the freely running back end does not allow in
// normal use. Configuration writes on the cfg channel are always taken
// (cfg_ready is tied high) and must only be made while no pair is in flight.
// status reads 0 for a computed force, 1 beyond cutoff, 2 for coincident
// centres and 3 when a component clamped.
module elastic_contact_pair_force_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  ecpf_pkg::item_t                    item,
	output logic                               done,
	output ecpf_pkg::result_t                  result,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [ecpf_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [31:0]                        cfg_data
);
	import ecpf_pkg::*;

	cfg_t     cfg_q;
	logic     push;
	fe_word_t fe_word;
	logic     q_valid;
	fe_word_t q_word;
	logic     q_near_full;

	// Register file: drop writes to unknown indexes.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.energy <= ENERGY_RST;
			cfg_q.use_cut <= 1'b0;
			cfg_q.cut_len <= CUT_LEN_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_ENERGY:  cfg_q.energy <= cfg_data[30:0];
				REG_USE_CUT: cfg_q.use_cut <= cfg_data[0];
				REG_CUT_LEN: cfg_q.cut_len <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	// Front: take the pair, form separations and radius sum.
	ecpf_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.item        (item),
		.q_near_full (q_near_full),
		.busy        (busy),
		.push        (push),
		.word        (fe_word)
	);

	// Queue: hold classified words until the back end takes them.
	ecpf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wdata     (fe_word),
		.rvalid    (q_valid),
		.rdata     (q_word),
		.near_full (q_near_full)
	);

	// Back: roots, magnitude, per-axis divide, saturation.
	ecpf_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (q_valid),
		.in_word  (q_word),
		.cfg      (cfg_q),
		.done     (done),
		.result   (result)
	);

endmodule

`default_nettype wire

// File: rtl/ecpf_front.sv
`default_nettype none

module ecpf_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  ecpf_pkg::item_t   item,
	input  logic              q_near_full,
	output logic              busy,
	output logic              push,
	output ecpf_pkg::fe_word_t word
);
	import ecpf_pkg::*;

	logic               accept;
	logic signed [31:0] a_c [3];
	logic signed [31:0] b_c [3];
	logic signed [32:0] diff [3];
	fe_word_t           nxt;
	logic               v_s1;
	fe_word_t           w_s1;

	assign busy = q_near_full;
	assign accept = start && !busy;

	assign a_c[0] = item.a_x;
	assign a_c[1] = item.a_y;
	assign a_c[2] = item.a_z;
	assign b_c[0] = item.b_x;
	assign b_c[1] = item.b_y;
	assign b_c[2] = item.b_z;

	// separation, magnitude and direction per axis; drop unused axes
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			diff[k] = {b_c[k][31], b_c[k]} - {a_c[k][31], a_c[k]};
			if (k < DIMENSIONS) begin
				nxt.ad[k] = diff[k][32] ? 33'(-diff[k]) : 33'(diff[k]);
				nxt.neg[k] = diff[k][32];
			end else begin
				nxt.ad[k] = '0;
				nxt.neg[k] = 1'b0;
			end
		end
		nxt.r1 = item.radius_a;
		nxt.r2 = item.radius_b;
		nxt.s = {2'b00, item.radius_a} + {2'b00, item.radius_b};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			w_s1 <= nxt;
		end
	end

	assign push = v_s1;
	assign word = w_s1;

endmodule

`default_nettype wire

// File: rtl/ecpf_queue.sv
`default_nettype none

module ecpf_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  ecpf_pkg::fe_word_t wdata,
	output logic               rvalid,
	output ecpf_pkg::fe_word_t rdata,
	output logic               near_full
);
	import ecpf_pkg::*;

	fe_word_t          mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              pop;

	// back end never stalls: pop whenever a word is held
	assign pop = (count_q != '0);
	assign rvalid = pop;
	assign rdata = mem_q[rd_ptr_q];
	assign near_full = (count_q >= (QPTR_W + 1)'(QDEPTH - 1));

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/ecpf_back.sv
`default_nettype none

module ecpf_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  ecpf_pkg::fe_word_t in_word,
	input  ecpf_pkg::cfg_t     cfg,
	output logic               done,
	output ecpf_pkg::result_t  result
);
	import ecpf_pkg::*;

	typedef struct packed {
		logic [2:0][32:0] ad;
		logic [2:0]       neg;
		logic [32:0]      s;
		logic [67:0]      n;
		root_t            rt;
		logic [61:0]      rr;
		logic [65:0]      rem;
		logic [30:0]      q;
	} d_ctx_t;

	typedef struct packed {
		logic [2:0][32:0] ad;
		logic [2:0]       neg;
		logic             live;
		logic [1:0]       status;
		logic [64:0]      den;
		logic [32:0]      o;
		logic [67:0]      n_so;
		root_t            rt_so;
		logic [67:0]      n_sr;
		root_t            rt_sr;
	} c_ctx_t;

	typedef struct packed {
		logic [2:0][32:0] ad;
		logic [2:0]       neg;
		logic             live;
		logic [1:0]       status;
		logic [64:0]      den;
		logic [23:0]      sr;
		logic [65:0]      prod;
		logic [2:0][56:0] pp_hi;
		logic [2:0][56:0] pp_lo;
	} m_ctx_t;

	typedef struct packed {
		logic [2:0]       nz;
		logic [2:0]       neg;
		logic             live;
		logic [1:0]       status;
		logic [64:0]      den;
		logic [2:0][96:0] num;
		logic [2:0][65:0] rem;
		logic [2:0]       ovf;
		logic [2:0][31:0] q;
	} x_ctx_t;

	// products
	logic             v_s1;
	fe_word_t         w_s1;
	logic [2:0][65:0] sqr_s1;
	logic [61:0]      rr_s1;

	d_ctx_t dc_s [D_BITS+1];
	logic   dv_s [D_BITS+1];
	c_ctx_t cc_s [SO_BITS+1];
	logic   cv_s [SO_BITS+1];
	m_ctx_t m_s1, m_s2, m_s3;
	logic   mv_s1, mv_s2, mv_s3;
	x_ctx_t xc_s [Q_BITS+1];
	logic   xv_s [Q_BITS+1];

	d_ctx_t      d_init;
	c_ctx_t      c_init;
	logic [33:0] d_val;
	logic        cut;
	logic [30:0] energy_eff;
	result_t     res_nxt;
	logic        sat;
	logic [31:0] f_val [3];
	logic        done_q;
	result_t     result_q;

	always_ff @(posedge clk) begin
		if (in_valid) begin
			w_s1 <= in_word;
			for (int k = 0; k < 3; k++) begin
				sqr_s1[k] <= 66'(in_word.ad[k]) * 66'(in_word.ad[k]);
			end
			rr_s1 <= 62'(in_word.r1) * 62'(in_word.r2);
		end
	end

	// sum of squares; set up distance root and effective radius division
	always_comb begin
		d_init.ad = w_s1.ad;
		d_init.neg = w_s1.neg;
		d_init.s = w_s1.s;
		d_init.n = 68'(sqr_s1[0]) + 68'(sqr_s1[1]) + 68'(sqr_s1[2]);
		d_init.rt = '0;
		d_init.rr = rr_s1;
		d_init.rem = 66'(rr_s1[61:31]);
		d_init.q = '0;
	end

	always_ff @(posedge clk) begin
		dc_s[0] <= d_init;
	end

	for (genvar j = 0; j < D_BITS; j++) begin : g_droot
		localparam int RB = (j < RD_BITS) ? (RD_BITS - 1 - j) : 0;
		always_ff @(posedge clk) begin
			d_ctx_t nx;
			dstep_t ds;
			nx = dc_s[j];
			nx.rt = sqrt_step(dc_s[j].n, dc_s[j].rt, D_BITS - 1 - j);
			ds = div_step(dc_s[j].rem, 66'(dc_s[j].s), dc_s[j].rr[RB]);
			if (j < RD_BITS) begin
				nx.rem = ds.rem;
				nx.q = {dc_s[j].q[RD_BITS-2:0], ds.q};
			end
			dc_s[j+1] <= nx;
		end
	end

	// classify: cutoff, coincident centres, overlap
	always_comb begin
		d_val = dc_s[D_BITS].rt.r;
		cut = cfg.use_cut && (d_val >= 34'(cfg.cut_len));
		energy_eff = (cfg.energy == '0) ? 31'd1 : cfg.energy;
		c_init.ad = dc_s[D_BITS].ad;
		c_init.neg = dc_s[D_BITS].neg;
		c_init.live = !cut && (d_val != '0) && (d_val < 34'(dc_s[D_BITS].s));
		if (cut) begin
			c_init.status = ST_CUTOFF;
		end else if (d_val == '0) begin
			c_init.status = ST_COINCIDE;
		end else begin
			c_init.status = ST_OK;
		end
		c_init.den = 65'(energy_eff) * 65'(d_val);
		c_init.o = dc_s[D_BITS].s - d_val[32:0];
		c_init.n_so = 68'(c_init.o) << 16;
		c_init.rt_so = '0;
		c_init.n_sr = 68'(dc_s[D_BITS].q) << 16;
		c_init.rt_sr = '0;
	end

	always_ff @(posedge clk) begin
		cc_s[0] <= c_init;
	end

	for (genvar j = 0; j < SO_BITS; j++) begin : g_oroot
		always_ff @(posedge clk) begin
			c_ctx_t nx;
			nx = cc_s[j];
			nx.rt_so = sqrt_step(cc_s[j].n_so, cc_s[j].rt_so, SO_BITS - 1 - j);
			nx.rt_sr = sqrt_step(cc_s[j].n_sr, cc_s[j].rt_sr, SO_BITS - 1 - j);
			cc_s[j+1] <= nx;
		end
	end

	// magnitude: o^1.5, times sqrt of effective radius, then per-axis numerator
	always_ff @(posedge clk) begin
		m_ctx_t m2_nx;
		m_ctx_t m3_nx;
		m_s1.ad <= cc_s[SO_BITS].ad;
		m_s1.neg <= cc_s[SO_BITS].neg;
		m_s1.live <= cc_s[SO_BITS].live;
		m_s1.status <= cc_s[SO_BITS].status;
		m_s1.den <= cc_s[SO_BITS].den;
		m_s1.sr <= cc_s[SO_BITS].rt_sr.r[23:0];
		m_s1.prod <= 66'(cc_s[SO_BITS].o) * 66'(cc_s[SO_BITS].rt_so.r[24:0]);
		m_s1.pp_hi <= '0;
		m_s1.pp_lo <= '0;

		m2_nx = m_s1;
		m2_nx.prod = 66'(m_s1.prod[57:16]) * 66'(m_s1.sr);
		m_s2 <= m2_nx;

		m3_nx = m_s2;
		for (int k = 0; k < 3; k++) begin
			m3_nx.pp_hi[k] = 57'(m_s2.prod[63:40]) * 57'(m_s2.ad[k]);
			m3_nx.pp_lo[k] = 57'(m_s2.prod[39:16]) * 57'(m_s2.ad[k]);
		end
		m_s3 <= m3_nx;
	end

	always_ff @(posedge clk) begin
		xc_s[0].neg <= m_s3.neg;
		xc_s[0].live <= m_s3.live;
		xc_s[0].status <= m_s3.status;
		xc_s[0].den <= m_s3.den;
		for (int k = 0; k < 3; k++) begin
			xc_s[0].nz[k] <= (m_s3.ad[k] != '0);
			xc_s[0].num[k] <= ((97'(m_s3.pp_hi[k]) << 24) + 97'(m_s3.pp_lo[k])) << 16;
		end
		xc_s[0].rem <= '0;
		xc_s[0].ovf <= '0;
		xc_s[0].q <= '0;
	end

	// per-axis quotient, one bit a stage; the first stage flags overflow
	for (genvar j = 0; j < Q_BITS; j++) begin : g_div
		always_ff @(posedge clk) begin
			x_ctx_t      nx;
			dstep_t      ds;
			logic [65:0] rem_in;
			nx = xc_s[j];
			for (int k = 0; k < 3; k++) begin
				if (j == 0) begin
					nx.ovf[k] = (xc_s[j].num[k][96:32] >= xc_s[j].den);
					rem_in = 66'(xc_s[j].num[k][96:32]);
				end else begin
					rem_in = xc_s[j].rem[k];
				end
				ds = div_step(rem_in, 66'(xc_s[j].den), xc_s[j].num[k][Q_BITS-1-j]);
				nx.rem[k] = ds.rem;
				nx.q[k] = {xc_s[j].q[k][30:0], ds.q};
			end
			xc_s[j+1] <= nx;
		end
	end

	// sign, saturate, pack
	always_comb begin
		sat = 1'b0;
		for (int k = 0; k < 3; k++) begin
			if (!xc_s[Q_BITS].live || !xc_s[Q_BITS].nz[k]) begin
				f_val[k] = '0;
			end else if (!xc_s[Q_BITS].neg[k]) begin
				if (xc_s[Q_BITS].ovf[k] || (xc_s[Q_BITS].q[k] > 32'h8000_0000)) begin
					f_val[k] = 32'h8000_0000;
					sat = 1'b1;
				end else begin
					f_val[k] = 32'd0 - xc_s[Q_BITS].q[k];
				end
			end else begin
				if (xc_s[Q_BITS].ovf[k] || (xc_s[Q_BITS].q[k] > 32'h7FFF_FFFF)) begin
					f_val[k] = 32'h7FFF_FFFF;
					sat = 1'b1;
				end else begin
					f_val[k] = xc_s[Q_BITS].q[k];
				end
			end
		end
		res_nxt.force_x = f_val[0];
		res_nxt.force_y = f_val[1];
		res_nxt.force_z = f_val[2];
		res_nxt.status = sat ? ST_SAT : xc_s[Q_BITS].status;
	end

	always_ff @(posedge clk) begin
		result_q <= res_nxt;
	end

	// valid chain follows every stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			for (int j = 0; j <= D_BITS; j++) begin
				dv_s[j] <= 1'b0;
			end
			for (int j = 0; j <= SO_BITS; j++) begin
				cv_s[j] <= 1'b0;
			end
			mv_s1 <= 1'b0;
			mv_s2 <= 1'b0;
			mv_s3 <= 1'b0;
			for (int j = 0; j <= Q_BITS; j++) begin
				xv_s[j] <= 1'b0;
			end
			done_q <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			dv_s[0] <= v_s1;
			for (int j = 0; j < D_BITS; j++) begin
				dv_s[j+1] <= dv_s[j];
			end
			cv_s[0] <= dv_s[D_BITS];
			for (int j = 0; j < SO_BITS; j++) begin
				cv_s[j+1] <= cv_s[j];
			end
			mv_s1 <= cv_s[SO_BITS];
			mv_s2 <= mv_s1;
			mv_s3 <= mv_s2;
			xv_s[0] <= mv_s3;
			for (int j = 0; j < Q_BITS; j++) begin
				xv_s[j+1] <= xv_s[j];
			end
			done_q <= xv_s[Q_BITS];
		end
	end

	assign done = done_q;
	assign result = result_q;

endmodule

`default_nettype wire

// File: rtl/ecpf_checker.sv
`default_nettype none

`include "elastic_contact_pair_force_unit_macros.svh"

module ecpf_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              busy,
	input logic              done,
	input ecpf_pkg::result_t result,
	input logic              cfg_valid,
	input logic              cfg_ready
);
	import ecpf_pkg::*;

	`ECPF_ASSERT_IMP(a_cfg_ready, cfg_valid, cfg_ready)
	`ECPF_ASSERT_IMP(a_cutoff_zero, done && (result.status == ST_CUTOFF),
		(result.force_x == 0) && (result.force_y == 0) && (result.force_z == 0))
	`ECPF_ASSERT_IMP(a_coinc_zero, done && (result.status == ST_COINCIDE),
		(result.force_x == 0) && (result.force_y == 0) && (result.force_z == 0))
	`ECPF_ASSERT_IMP(a_sat_clamped, done && (result.status == ST_SAT),
		(result.force_x == 32'h7FFF_FFFF) || (result.force_x == 32'h8000_0000) ||
		(result.force_y == 32'h7FFF_FFFF) || (result.force_y == 32'h8000_0000) ||
		(result.force_z == 32'h7FFF_FFFF) || (result.force_z == 32'h8000_0000))
	`ECPF_ASSERT_NXT(a_busy_short, busy, !busy)

endmodule

bind elastic_contact_pair_force_unit ecpf_checker u_ecpf_checker (.*);

`default_nettype wire

// File: verif/elastic_contact_pair_force_unit_tb.sv
`timescale 1ns / 100ps
`default_nettype none

module elastic_contact_pair_force_unit_tb;
	import ecpf_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int PIPE_LATENCY = 100;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	item_t item;
	logic done;
	result_t result;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [31:0] cfg_data;

	// shadow copy of the register file, updated on each accepted write
	logic [30:0] energy_shadow;
	logic use_cut_shadow;
	logic [30:0] cut_len_shadow;

	result_t pending_forces[$];
	int mismatch_count;
	int cycle_count;

	elastic_contact_pair_force_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.done(done),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Floor square root of a value below 2^68; the result fits in 34 bits.
	function automatic logic [63:0] floor_root(input logic [127:0] n);
		logic [63:0] r;
		logic [63:0] c;
		r = '0;
		for (int b = 33; b >= 0; b--) begin
			c = r | (64'd1 << b);
			if ({64'd0, c} * {64'd0, c} <= n)
				r = c;
		end
		return r;
	endfunction

	// Work out the force word for one pair under the current shadow registers.
	function automatic result_t contact_force(input item_t p);
		result_t f;
		logic signed [33:0] delta [3];
		logic [32:0] mag [3];
		logic [127:0] sum_sq;
		logic [63:0] span, r1, r2, rsum, over, over15, reff, push;
		logic [127:0] den, quo;
		f = '0;
		f.status = ST_OK;
		delta[0] = 34'(p.b_x) - 34'(p.a_x);
		delta[1] = 34'(p.b_y) - 34'(p.a_y);
		delta[2] = 34'(p.b_z) - 34'(p.a_z);
		sum_sq = '0;
		for (int k = 0; k < 3; k++) begin
			mag[k] = delta[k] < 0 ? 33'(-delta[k]) : 33'(delta[k]);
			if (k < DIMENSIONS)
				sum_sq += {95'd0, mag[k]} * {95'd0, mag[k]};
		end
		span = floor_root(sum_sq);
		r1 = {33'd0, p.radius_a};
		r2 = {33'd0, p.radius_b};
		rsum = r1 + r2;
		if (use_cut_shadow && span >= {33'd0, cut_len_shadow}) begin
			f.status = ST_CUTOFF;
		end else if (span == 0) begin
			f.status = ST_COINCIDE;
		end else if (span < rsum) begin
			over = rsum - span;
			over15 = (over * floor_root({64'd0, over << 16})) >> 16;
			reff = (r1 * r2) / rsum;
			push = (over15 * floor_root({64'd0, reff << 16})) >> 16;
			den = {64'd0, (energy_shadow == 0) ? 64'd1 : {33'd0, energy_shadow}} * {64'd0, span};
			for (int k = 0; k < DIMENSIONS; k++) begin
				if (delta[k] == 0)
					continue;
				quo = ({64'd0, push << 16} * {95'd0, mag[k]}) / den;
				// force on A points away from B
				if (delta[k] > 0) begin
					if (quo > 128'h8000_0000) begin
						f.status = ST_SAT;
						quo = 128'h8000_0000;
					end
					case (k)
						0: f.force_x = -quo[31:0];
						1: f.force_y = -quo[31:0];
						default: f.force_z = -quo[31:0];
					endcase
				end else begin
					if (quo > 128'h7FFF_FFFF) begin
						f.status = ST_SAT;
						quo = 128'h7FFF_FFFF;
					end
					case (k)
						0: f.force_x = quo[31:0];
						1: f.force_y = quo[31:0];
						default: f.force_z = quo[31:0];
					endcase
				end
			end
		end
		return f;
	endfunction

	function automatic item_t make_pair(input int ax, input int ay, input int az,
			input int bx, input int by, input int bz, input int unsigned ra,
			input int unsigned rb);
		item_t p;
		p.a_x = ax;
		p.a_y = ay;
		p.a_z = az;
		p.b_x = bx;
		p.b_y = by;
		p.b_z = bz;
		p.radius_a = ra[30:0];
		p.radius_b = rb[30:0];
		return p;
	endfunction

	// Mostly back-to-back, sometimes a short pause, rarely a long one.
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(99);
		if (roll < 60)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// Offer one pair, hold it until taken, then idle for the requested gap.
	// start stays high across back-to-back words.
	task automatic send_pair(input item_t p, input int gap);
		start <= 1'b1;
		item <= p;
		do
			@(posedge clk);
		while (busy);
		pending_forces.push_back(contact_force(p));
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Write one register, then idle before the next write.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_ENERGY: energy_shadow = value[30:0];
			REG_USE_CUT: use_cut_shadow = value[0];
			REG_CUT_LEN: cut_len_shadow = value[30:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// Drop start and wait until every word in flight has come back.
	task automatic drain();
		start <= 1'b0;
		do
			@(posedge clk);
		while (pending_forces.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	// Overlapping pair: random centre, offset within the radii, random scale.
	function automatic item_t touching_pair();
		int unsigned ra, rb, reach;
		int ax, ay, az;
		int shift;
		shift = $urandom_range(0, 13);
		ra = $urandom_range(1, 32'h0002_0000) << shift;
		rb = $urandom_range(1, 32'h0002_0000) << shift;
		reach = (ra + rb) / 2 + 1;
		ax = int'($urandom()) / 4;
		ay = int'($urandom()) / 4;
		az = int'($urandom()) / 4;
		return make_pair(ax, ay, az,
			ax + int'($urandom_range(0, reach)) - int'(reach / 2),
			ay + int'($urandom_range(0, reach)) - int'(reach / 2),
			az + int'($urandom_range(0, reach)) - int'(reach / 2), ra, rb);
	endfunction

	function automatic item_t noise_pair();
		return make_pair($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
			$urandom(), $urandom(), $urandom());
	endfunction

	task automatic random_burst(input int count);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(99) < 75)
				send_pair(touching_pair(), pick_gap());
			else
				send_pair(noise_pair(), pick_gap());
		end
	endtask

	// Axis extremes, coincidence, no overlap, saturation and dead-on contact.
	task automatic test_directed_cases();
		send_pair(make_pair(0, 0, 0, 0, 0, 0, 32'h0001_0000, 32'h0001_0000), 0);
		send_pair(make_pair(0, 0, 0, 32'h0001_0000, 0, 0, 32'h0001_0000, 32'h0001_0000), 0);
		send_pair(make_pair(0, 0, 0, 0, -32'sh0000_8000, 0, 32'h0001_0000, 32'h0001_0000), 0);
		send_pair(make_pair(0, 0, 0, 0, 0, 32'h0000_4000, 32'h0000_8000, 32'h0000_8000), 0);
		send_pair(make_pair(0, 0, 0, 32'h0002_0000, 0, 0, 32'h0001_0000, 32'h0001_0000), 1);
		send_pair(make_pair(0, 0, 0, 32'h0100_0000, 0, 0, 32'h0001_0000, 32'h0001_0000), 0);
		send_pair(make_pair(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
			32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF), 0);
		send_pair(make_pair(32'sh7FFF_FFFF, 0, 32'sh8000_0000,
			32'sh8000_0000, 0, 32'sh7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF), 2);
		send_pair(make_pair(0, 0, 0, 1, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF), 0);
		send_pair(make_pair(0, 0, 0, 1, -1, 1, 32'h7FFF_FFFF, 0), 0);
		send_pair(make_pair(0, 0, 0, 32'h0000_1000, 0, 0, 0, 0), 0);
		send_pair(make_pair(5, 5, 5, 5, 5, 5, 0, 0), 0);
		send_pair(make_pair(-32'sh0001_0000, 32'h0000_3000, 0, 32'h0000_4000, 0,
			-32'sh0000_2000, 32'h0001_8000, 32'h0000_C000), 3);
		drain();
	endtask

	task automatic test_default_registers();
		random_burst(150);
		drain();
	endtask

	// Enable the cutoff: hit the boundary exactly, just inside and at coincidence, then run bursts at other lengths.
	task automatic test_cutoff();
		write_reg(REG_USE_CUT, 32'd1);
		write_reg(REG_CUT_LEN, 32'h0000_8000);
		send_pair(make_pair(0, 0, 0, 32'h0000_8000, 0, 0, 32'h0001_0000, 32'h0001_0000), 0);
		send_pair(make_pair(0, 0, 0, 32'h0000_7FFF, 0, 0, 32'h0001_0000, 32'h0001_0000), 0);
		send_pair(make_pair(0, 0, 0, 0, 0, 0, 32'h0001_0000, 32'h0001_0000), 0);
		drain();
		write_reg(REG_CUT_LEN, 32'd0);
		send_pair(make_pair(0, 0, 0, 0, 0, 0, 32'h0001_0000, 32'h0001_0000), 0);
		send_pair(touching_pair(), 0);
		drain();
		write_reg(REG_CUT_LEN, 32'hFFFF_FFFF);
		random_burst(20);
		drain();
		write_reg(REG_CUT_LEN, 32'h0004_0000);
		random_burst(80);
		drain();
		write_reg(REG_USE_CUT, 32'd0);
	endtask

	// Sweep the divisor across its range, zero and the top bit included.
	task automatic test_energy_sweep();
		write_reg(REG_ENERGY, 32'd0);
		random_burst(30);
		drain();
		write_reg(REG_ENERGY, 32'd1);
		random_burst(30);
		drain();
		write_reg(REG_ENERGY, 32'hFFFF_FFFF);
		random_burst(30);
		drain();
		write_reg(REG_ENERGY, 32'h0001_0000);
		random_burst(40);
		drain();
		write_reg(REG_ENERGY, $urandom());
		write_reg(REG_USE_CUT, $urandom());
		write_reg(REG_CUT_LEN, $urandom());
		random_burst(60);
		drain();
	endtask

	// Hold off until the pipe is empty, then resume without reconfiguring.
	task automatic test_pipe_empty_pause();
		random_burst(10);
		drain();
		random_burst(40);
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_ENERGY;
		cfg_data = '0;
		energy_shadow = ENERGY_RST;
		use_cut_shadow = 1'b0;
		cut_len_shadow = CUT_LEN_RST;
		mismatch_count = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();
		test_default_registers();
		test_cutoff();
		test_energy_sweep();
		test_pipe_empty_pause();

		repeat (PIPE_LATENCY + 10) @(posedge clk);
		if (mismatch_count == 0 && pending_forces.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// Compare each word on result with the oldest expectation.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && done) begin
			if (pending_forces.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected word: got %h", result);
			end else begin
				want = pending_forces.pop_front();
				if (result.force_x !== want.force_x || result.force_y !== want.force_y ||
						result.force_z !== want.force_z || result.status !== want.status) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("mismatch: want x=%h y=%h z=%h st=%0d, got x=%h y=%h z=%h st=%0d",
							want.force_x, want.force_y, want.force_z, want.status,
							result.force_x, result.force_y, result.force_z, result.status);
				end
			end
		end
	end

	// Stop a hung run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial cycle_count = 0;

endmodule

`default_nettype wire
